// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Wraps concurrent assertions so that they drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/dstg_pkg.sv =====
// ----------------------------------------------------------------------------
// dstg_pkg
// Types, constants and the quarter-wave sine table of the tick generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dstg_pkg;

  // Sine table geometry.
  localparam int SINE_DEPTH  = 1024;
  localparam int AUDIO_RATE  = 44100;
  localparam int IDX_W       = $clog2(SINE_DEPTH);
  localparam int QTR_W       = IDX_W - 2;
  localparam int QTR_DEPTH   = SINE_DEPTH / 4;
  localparam int MAG_W       = 15;

  // Datapath widths.
  localparam int PHASE_W     = 32;
  localparam int ENV_W       = 16;
  localparam int VOL_W       = 16;
  localparam int DUR_W       = 20;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 61;
  localparam int MUL_B_W     = 16;
  localparam int MUL_CNT_W   = $clog2(MUL_B_W);
  localparam int SCALE_SHIFT = 47;
  localparam int CFG_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  // Register reset values and fixed gains.
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd194783094;
  localparam logic [ENV_W-1:0]   DECAY_RST      = 16'd65388;
  localparam logic [VOL_W-1:0]   VOLUME_RST     = 16'd16384;
  localparam logic [DUR_W-1:0]   DURATION_RST   = DUR_W'(AUDIO_RATE / 20);
  localparam logic [MUL_B_W-1:0] GAIN_Q16       = 16'd13107;
  localparam logic [ENV_W-1:0]   ENV_FULL       = 16'hFFFF;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_DECAY      = 2'd1,
    REG_VOLUME     = 2'd2,
    REG_DURATION   = 2'd3
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_VOL,
    S_GAIN,
    S_DECAY,
    S_FINISH
  } state_t;

  // Serial multiplier request and response.
  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef logic [MAG_W-1:0] qsine_t [QTR_DEPTH];

  // Magnitude of sin for quarter-wave position m (m = QTR_DEPTH is the peak),
  // from a fixed-point Taylor series in Q2.30, rounded to an unsigned Q0.15 magnitude (sin times 32767).
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned m);
    longint unsigned f;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    f    = 64'(m) << (30 - QTR_W);
    x    = (f * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = x;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      unique case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    return MAG_W'(v);
  endfunction

  function automatic qsine_t build_qsine();
    qsine_t t;
    for (int m = 0; m < QTR_DEPTH; m++) begin
      t[m] = sine_mag(m);
    end
    return t;
  endfunction

  // Quarter-wave table and the value at a quarter turn.
  localparam qsine_t           QSINE     = build_qsine();
  localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QTR_DEPTH);

endpackage

`default_nettype wire

// ===== sv/dstg_ifs.sv =====
// ----------------------------------------------------------------------------
// Tick generator channels
// Request channel (one sample per request) and sample result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dstg_req_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface dstg_smp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dstg_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;
  logic                                 active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink (input valid, input sample, input last, input active, output ready);
endinterface

`default_nettype wire

// ===== sv/dstg_sermul.sv =====
// ----------------------------------------------------------------------------
// dstg_sermul
// Serial shift-and-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dstg_sermul (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dstg_pkg::mul_req_t  req,
  output dstg_pkg::mul_rsp_t       rsp
);

  localparam logic [dstg_pkg::MUL_CNT_W-1:0] LAST_STEP =
    dstg_pkg::MUL_CNT_W'(dstg_pkg::MUL_B_W - 1);

  logic                             busy;
  logic [dstg_pkg::MUL_CNT_W-1:0]   cnt;
  logic [dstg_pkg::PROD_W-1:0]      a_sh;
  logic [dstg_pkg::MUL_B_W-1:0]     b_sh;
  logic [dstg_pkg::PROD_W-1:0]      acc;
  logic [dstg_pkg::PROD_W-1:0]      sum;

  // Add the shifted multiplicand when the current multiplier bit is set.
  assign sum      = acc + (b_sh[0] ? a_sh : '0);
  assign rsp.done = busy && (cnt == LAST_STEP);
  assign rsp.prod = sum;

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (rsp.done) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh <= req.a;
      b_sh <= req.b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= sum;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  `ASSERT_NXT(a_start_loads, clk, rst, req.start, busy && (cnt == '0), "multiply did not start")
  `ASSERT_NXT(a_busy_holds, clk, rst, busy && !rsp.done && !req.start, busy, "multiply stopped early")
  `ASSERT_NXT(a_done_stops, clk, rst, rsp.done && !req.start, !busy, "multiply ran past its last step")

endmodule

`default_nettype wire

// ===== sv/decaying_sine_tick_generator_top.sv =====
// ----------------------------------------------------------------------------
// decaying_sine_tick_generator_top
// Tick sound generator: sine phase accumulator times a decaying envelope,
// volume and a fixed gain of 0.2, one signed 16-bit sample per request.
// ----------------------------------------------------------------------------
// A sample of a running sound takes four 16-step multiplies in the shared
// bit-serial multiplier and is then loaded into the output register; a silent
// sample skips the multiplies. No new request is taken until the last sample is
// loaded, and loading waits while the output holds an unaccepted sample.
// Reset (synchronous): registers return to defaults, sound stops, output empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module decaying_sine_tick_generator_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dstg_req_if.sink                               req,
  dstg_smp_if.source                             smp,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dstg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [dstg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [dstg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  // Configuration registers.
  logic [dstg_pkg::PHASE_W-1:0] phase_step;
  logic [dstg_pkg::ENV_W-1:0]   decay_factor;
  logic [dstg_pkg::VOL_W-1:0]   volume;
  logic [dstg_pkg::DUR_W-1:0]   duration_samples;

  // Sound state.
  logic [dstg_pkg::PHASE_W-1:0] phase_acc;
  logic [dstg_pkg::ENV_W-1:0]   env;
  logic [dstg_pkg::DUR_W-1:0]   samples_done;
  logic                         running;

  dstg_pkg::state_t state;
  dstg_pkg::state_t state_next;

  // Staged result and output register.
  logic                                 neg;
  logic [dstg_pkg::SAMPLE_W-1:0]        res_sample;
  logic                                 res_last;
  logic                                 res_active;
  logic                                 out_valid;
  logic signed [dstg_pkg::SAMPLE_W-1:0] out_sample;
  logic                                 out_last;
  logic                                 out_active;
  logic                                 out_load;

  // Request-time values.
  logic                          accept;
  logic [dstg_pkg::PHASE_W-1:0]  phase_eff;
  logic [dstg_pkg::ENV_W-1:0]    env_eff;
  logic [dstg_pkg::DUR_W-1:0]    cnt_eff;
  logic [dstg_pkg::DUR_W-1:0]    cnt_inc;
  logic                          run_eff;
  logic                          is_last;
  logic [dstg_pkg::IDX_W-1:0]    idx;
  logic [dstg_pkg::QTR_W-1:0]    qidx;
  logic [dstg_pkg::QTR_W-1:0]    qidx_mir;
  logic [dstg_pkg::MAG_W-1:0]    mag;

  dstg_pkg::mul_req_t mul_req;
  dstg_pkg::mul_rsp_t mul_rsp;

  logic                      cfg_wr;
  dstg_pkg::reg_idx_t        cfg_sel;

  // Signed saturation of the scaled magnitude.
  function automatic logic [dstg_pkg::SAMPLE_W-1:0] saturate(
    input logic [dstg_pkg::PROD_W-dstg_pkg::SCALE_SHIFT-1:0] m,
    input logic                                              is_neg
  );
    logic [dstg_pkg::SAMPLE_W:0] m17;
    m17 = (dstg_pkg::SAMPLE_W + 1)'(m);
    if (is_neg) begin
      return (m17 > 17'd32768) ? 16'h8000 : dstg_pkg::SAMPLE_W'(17'd0 - m17);
    end
    return (m17 > 17'd32767) ? 16'h7FFF : m17[dstg_pkg::SAMPLE_W-1:0];
  endfunction

  // APB register port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = dstg_pkg::reg_idx_t'(paddr[dstg_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= dstg_pkg::PHASE_STEP_RST;
      decay_factor     <= dstg_pkg::DECAY_RST;
      volume           <= dstg_pkg::VOLUME_RST;
      duration_samples <= dstg_pkg::DURATION_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        dstg_pkg::REG_PHASE_STEP: phase_step       <= pwdata;
        dstg_pkg::REG_DECAY:      decay_factor     <= pwdata[dstg_pkg::ENV_W-1:0];
        dstg_pkg::REG_VOLUME:     volume           <= pwdata[dstg_pkg::VOL_W-1:0];
        dstg_pkg::REG_DURATION:   duration_samples <= pwdata[dstg_pkg::DUR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      dstg_pkg::REG_PHASE_STEP: prdata = phase_step;
      dstg_pkg::REG_DECAY:      prdata = dstg_pkg::APB_DATA_W'(decay_factor);
      dstg_pkg::REG_VOLUME:     prdata = dstg_pkg::APB_DATA_W'(volume);
      dstg_pkg::REG_DURATION:   prdata = dstg_pkg::APB_DATA_W'(duration_samples);
    endcase
  end

  // A start request restarts phase, envelope and count before this sample.
  assign accept    = req.valid && req.ready;
  assign phase_eff = req.start_req ? '0 : phase_acc;
  assign env_eff   = req.start_req ? dstg_pkg::ENV_FULL : env;
  assign cnt_eff   = req.start_req ? '0 : samples_done;
  assign run_eff   = req.start_req ? (duration_samples != '0) : running;
  assign cnt_inc   = cnt_eff + 1'b1;
  assign is_last   = cnt_inc >= duration_samples;

  // Quarter-wave table lookup; odd quadrants read mirrored, the upper half
  // turn is negated.
  assign idx      = phase_eff[dstg_pkg::PHASE_W-1 -: dstg_pkg::IDX_W];
  assign qidx     = idx[dstg_pkg::QTR_W-1:0];
  assign qidx_mir = ~qidx + 1'b1;

  always_comb begin
    if (idx[dstg_pkg::QTR_W]) begin
      mag = (qidx == '0) ? dstg_pkg::SINE_PEAK : dstg_pkg::QSINE[qidx_mir];
    end else begin
      mag = dstg_pkg::QSINE[qidx];
    end
  end

  // Shared bit-serial multiplier.
  dstg_sermul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dstg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier launches: sine*env, *volume, *gain, env*decay.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mul_req    = '0;
    out_load   = 1'b0;
    unique case (state)
      dstg_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (run_eff) begin
            mul_req.start = 1'b1;
            mul_req.a     = dstg_pkg::PROD_W'(mag);
            mul_req.b     = env_eff;
            state_next    = dstg_pkg::S_ENV;
          end else begin
            state_next = dstg_pkg::S_FINISH;
          end
        end
      end
      dstg_pkg::S_ENV: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod;
          mul_req.b     = volume;
          state_next    = dstg_pkg::S_VOL;
        end
      end
      dstg_pkg::S_VOL: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod;
          mul_req.b     = dstg_pkg::GAIN_Q16;
          state_next    = dstg_pkg::S_GAIN;
        end
      end
      dstg_pkg::S_GAIN: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = dstg_pkg::PROD_W'(env);
          mul_req.b     = decay_factor;
          state_next    = dstg_pkg::S_DECAY;
        end
      end
      dstg_pkg::S_DECAY: begin
        if (mul_rsp.done) begin
          state_next = dstg_pkg::S_FINISH;
        end
      end
      dstg_pkg::S_FINISH: begin
        if (!out_valid || smp.ready) begin
          out_load   = 1'b1;
          state_next = dstg_pkg::S_IDLE;
        end
      end
      default: state_next = dstg_pkg::S_IDLE;
    endcase
  end

  // Sound state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      env          <= '0;
      samples_done <= '0;
      running      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (run_eff) begin
          phase_acc    <= phase_eff + phase_step;
          env          <= env_eff;
          samples_done <= cnt_inc;
          running      <= !is_last;
        end else begin
          phase_acc    <= phase_eff;
          env          <= env_eff;
          samples_done <= cnt_eff;
          running      <= 1'b0;
        end
      end
      if ((state == dstg_pkg::S_DECAY) && mul_rsp.done) begin
        env <= mul_rsp.prod[2*dstg_pkg::ENV_W-1:dstg_pkg::ENV_W];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (smp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result staging and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (run_eff) begin
        neg        <= idx[dstg_pkg::IDX_W-1];
        res_last   <= is_last;
        res_active <= 1'b1;
      end else begin
        res_sample <= '0;
        res_last   <= 1'b0;
        res_active <= 1'b0;
      end
    end
    if ((state == dstg_pkg::S_GAIN) && mul_rsp.done) begin
      res_sample <= saturate(mul_rsp.prod[dstg_pkg::PROD_W-1:dstg_pkg::SCALE_SHIFT], neg);
    end
    if (out_load) begin
      out_sample <= res_sample;
      out_last   <= res_last;
      out_active <= res_active;
    end
  end

  assign smp.valid  = out_valid;
  assign smp.sample = out_sample;
  assign smp.last   = out_last;
  assign smp.active = out_active;

  `ASSERT_IMP(a_done_in_mul, clk, rst, mul_rsp.done, (state == dstg_pkg::S_ENV) || (state == dstg_pkg::S_VOL) || (state == dstg_pkg::S_GAIN) || (state == dstg_pkg::S_DECAY), "multiply finished outside a multiply step")
  `ASSERT_NXT(a_decay_to_finish, clk, rst, (state == dstg_pkg::S_DECAY) && mul_rsp.done, state == dstg_pkg::S_FINISH, "envelope update did not stage the result")
  `ASSERT_IMP(a_silent_zero, clk, rst, smp.valid && !smp.active, smp.sample == '0, "silent sample is not zero")
  `ASSERT_IMP(a_last_active, clk, rst, smp.valid && smp.last, smp.active, "last flag on a silent sample")

endmodule

`default_nettype wire
